// ----- design/sqvs_pkg.sv -----
package sqvs_pkg;

    // Fraction bits of the sine and cosine table (Q1.TRIG_FRAC_BITS).
    localparam int TRIG_FRAC_BITS = 14;

    // Widths that follow from the trig fraction.
    localparam int SIN_W  = TRIG_FRAC_BITS + 1;   // table magnitude, 0 .. 2^F
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;   // signed sine or cosine
    localparam int PROD_W = TRIG_W + 16;          // trig times a 15-bit size
    localparam int CEN_W  = TRIG_FRAC_BITS + 18;  // doubled center, scaled by 2^F
    localparam int SUM_W  = TRIG_FRAC_BITS + 20;  // rotated corner before rounding

    // Stream payload widths.
    localparam int S_DATA_W = 184;
    localparam int M_DATA_W = 112;

    localparam int ANGLE_W = 9;
    localparam int TEX_W   = 17;
    localparam int SIZE_W  = 15;
    localparam int COLOR_W = 24;

    localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

    // Table of sin(k degrees) for k = 0 .. 90.
    localparam int SIN_ENTRIES = 91;
    localparam int SIN_IDX_W   = 7;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [SIN_ENTRIES-1:0][SIN_W-1:0] sin_table_t;

    // Taylor series through x^17 in Q2.30 with truncating products, then
    // rounded half up to the table precision. Evaluated at elaboration only.
    function automatic sin_table_t build_sin_table();
        sin_table_t        tbl;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        int                k;
        for (k = 0; k < SIN_ENTRIES; k++)
        begin
            x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            // Odd powers x^3 .. x^17, each term divided by the next two
            // factorial factors, with alternating signs.
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + longint'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            tbl[k] = SIN_W'(sum);
        end
        return tbl;
    endfunction

    localparam sin_table_t SIN_TABLE = build_sin_table();

    // Texture corner choice per mirror code and corner.
    // Bit PICK_U1 selects u1 for s, bit PICK_V1 selects v1 for t.
    localparam int PICK_U1 = 1;
    localparam int PICK_V1 = 0;
    typedef logic [3:0][3:0][1:0] tex_pick_t;
    localparam tex_pick_t TEX_PICK = {
        {2'd1, 2'd3, 2'd2, 2'd0},   // vertical flip
        {2'd3, 2'd1, 2'd0, 2'd2},   // both flips
        {2'd2, 2'd0, 2'd1, 2'd3},   // horizontal flip
        {2'd0, 2'd2, 2'd3, 2'd1}    // no flip
    };

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // One sprite as received.
    typedef struct packed {
        logic signed [15:0]   pos_x;
        logic signed [15:0]   pos_y;
        logic signed [15:0]   depth;
        logic [SIZE_W-1:0]    width;
        logic [SIZE_W-1:0]    height;
        logic [ANGLE_W-1:0]   angle;
        logic [TEX_W-1:0]     tex_u;
        logic [TEX_W-1:0]     tex_v;
        logic [TEX_W-1:0]     tex_w;
        logic [TEX_W-1:0]     tex_h;
        logic [COLOR_W-1:0]   color;
        logic [1:0]           mirror;
    } sprite_t;

    // Sprite after trig lookup and texture corner saturation.
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
        logic signed [CEN_W-1:0]  cx2;
        logic signed [CEN_W-1:0]  cy2;
        logic signed [15:0]       depth;
        logic [TEX_W-1:0]         u0;
        logic [TEX_W-1:0]         v0;
        logic [TEX_W-1:0]         u1;
        logic [TEX_W-1:0]         v1;
        logic [COLOR_W-1:0]       color;
        logic [1:0]               mirror;
    } trig_t;

    // Sprite with the rotation products, held while its four corners go out.
    typedef struct packed {
        logic signed [PROD_W-1:0] cw;
        logic signed [PROD_W-1:0] sh;
        logic signed [PROD_W-1:0] sw;
        logic signed [PROD_W-1:0] ch;
        logic signed [CEN_W-1:0]  cx2;
        logic signed [CEN_W-1:0]  cy2;
        logic signed [15:0]       depth;
        logic [TEX_W-1:0]         u0;
        logic [TEX_W-1:0]         v0;
        logic [TEX_W-1:0]         u1;
        logic [TEX_W-1:0]         v1;
        logic [COLOR_W-1:0]       color;
        logic [1:0]               mirror;
    } quad_t;

    // One finished vertex.
    typedef struct packed {
        logic signed [15:0]   x;
        logic signed [15:0]   y;
        logic signed [15:0]   z;
        logic [TEX_W-1:0]     s;
        logic [TEX_W-1:0]     t;
        logic [COLOR_W-1:0]   color;
        logic [1:0]           corner;
        logic                 last;
    } vertex_t;

endpackage

// ----- design/sqvs_vertex.sv -----
module sqvs_vertex (
    input  sqvs_pkg::quad_t   quad,
    input  logic [1:0]        corner,
    output sqvs_pkg::vertex_t vert
);

    localparam logic signed [sqvs_pkg::SUM_W-1:0] HALF =
        sqvs_pkg::SUM_W'(longint'(1) <<< sqvs_pkg::TRIG_FRAC_BITS);
    localparam logic signed [sqvs_pkg::SUM_W-1:0] SAT_HI = sqvs_pkg::SUM_W'(32767);
    localparam logic signed [sqvs_pkg::SUM_W-1:0] SAT_LO = -sqvs_pkg::SUM_W'(32768);

    // Clamp a floored coordinate to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(logic signed [sqvs_pkg::SUM_W-1:0] val);
        logic signed [15:0] res;
        priority if (val > SAT_HI)
        begin
            res = 16'sh7fff;
        end
        else if (val < SAT_LO)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = val[15:0];
        end
        return res;
    endfunction

    logic                               x_neg;
    logic                               y_neg;
    logic signed [sqvs_pkg::SUM_W-1:0]  cw_e;
    logic signed [sqvs_pkg::SUM_W-1:0]  sh_e;
    logic signed [sqvs_pkg::SUM_W-1:0]  sw_e;
    logic signed [sqvs_pkg::SUM_W-1:0]  ch_e;
    logic signed [sqvs_pkg::SUM_W-1:0]  nx;
    logic signed [sqvs_pkg::SUM_W-1:0]  ny;
    logic signed [sqvs_pkg::SUM_W-1:0]  fx;
    logic signed [sqvs_pkg::SUM_W-1:0]  fy;
    logic [1:0]                         pick;

    // Corners 0 and 3 sit left of center, corners 0 and 1 below it.
    assign x_neg = (corner[0] == corner[1]);
    assign y_neg = !corner[1];

    // Rotate the corner offset, add the doubled center, round and floor.
    always_comb
    begin
        cw_e = x_neg ? -sqvs_pkg::SUM_W'(quad.cw) : sqvs_pkg::SUM_W'(quad.cw);
        sw_e = x_neg ? -sqvs_pkg::SUM_W'(quad.sw) : sqvs_pkg::SUM_W'(quad.sw);
        sh_e = y_neg ? -sqvs_pkg::SUM_W'(quad.sh) : sqvs_pkg::SUM_W'(quad.sh);
        ch_e = y_neg ? -sqvs_pkg::SUM_W'(quad.ch) : sqvs_pkg::SUM_W'(quad.ch);
        nx   = sqvs_pkg::SUM_W'(quad.cx2) + cw_e - sh_e + HALF;
        ny   = sqvs_pkg::SUM_W'(quad.cy2) + sw_e + ch_e + HALF;
        fx   = nx >>> (sqvs_pkg::TRIG_FRAC_BITS + 1);
        fy   = ny >>> (sqvs_pkg::TRIG_FRAC_BITS + 1);
    end

    // Texture corner follows the mirror flags.
    assign pick = sqvs_pkg::TEX_PICK[quad.mirror][corner];

    always_comb
    begin
        vert.x      = sat16(fx);
        vert.y      = sat16(fy);
        vert.z      = quad.depth;
        vert.s      = pick[sqvs_pkg::PICK_U1] ? quad.u1 : quad.u0;
        vert.t      = pick[sqvs_pkg::PICK_V1] ? quad.v1 : quad.v0;
        vert.color  = quad.color;
        vert.corner = corner;
        vert.last   = (corner == sqvs_pkg::CORNER_LAST);
    end

endmodule

// ----- design/sprite_quad_vertex_setup.sv -----
// Sprite quad vertex setup. Each sprite request on the slave stream becomes
// four vertex requests on the master stream, corners in the order bottom
// left, bottom right, top right, top left, the fourth marked with tlast.
// Every corner is rotated about the quad center by the whole-degree angle
// (taken modulo 360) with a Q1.14 sine/cosine table, rounded and saturated
// to signed Q12.4; depth and color are copied and the texture corner is
// chosen by the mirror flags. A sprite occupies the single vertex datapath
// for its four corners, one corner per cycle unless the output stalls, and
// a new sprite is taken while the previous one is still going out. An
// accepted sprite passes the input register, trig lookup register, product
// register and output register before its first vertex appears on the
// master stream. A low m_tready stalls the corner sequence.
module sprite_quad_vertex_setup (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[15:0], pos_y[31:16], depth[47:32], width[62:48], height[77:63],
    // angle[86:78], tex_u[103:87], tex_v[120:104], tex_w[137:121],
    // tex_h[154:138], color[178:155], mirror[180:179], zero fill above.
    input  logic [sqvs_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // vert_x[15:0], vert_y[31:16], vert_z[47:32], tex_s[64:48],
    // tex_t[81:65], vert_color[105:82], corner[107:106], zero fill above.
    output logic [sqvs_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    // Signed sine of a reduced angle (0 .. 359) from the first-quadrant table.
    function automatic logic signed [sqvs_pkg::TRIG_W-1:0] trig_at(
        logic [sqvs_pkg::ANGLE_W-1:0] ang
    );
        logic [sqvs_pkg::ANGLE_W-1:0]   idx;
        logic                           neg;
        logic signed [sqvs_pkg::TRIG_W-1:0] mag;
        priority if (ang <= 9'd90)
        begin
            idx = ang;
            neg = 1'b0;
        end
        else if (ang <= 9'd180)
        begin
            idx = 9'd180 - ang;
            neg = 1'b0;
        end
        else if (ang <= 9'd270)
        begin
            idx = ang - 9'd180;
            neg = 1'b1;
        end
        else
        begin
            idx = 9'd360 - ang;
            neg = 1'b1;
        end
        mag = signed'({1'b0, sqvs_pkg::SIN_TABLE[idx[sqvs_pkg::SIN_IDX_W-1:0]]});
        return neg ? -mag : mag;
    endfunction

    // Pipeline registers.
    logic                   a_valid_reg;
    sqvs_pkg::sprite_t      a_reg;
    logic                   b_valid_reg;
    sqvs_pkg::trig_t        b_reg;
    sqvs_pkg::trig_t        b_next;
    logic                   c_valid_reg;
    sqvs_pkg::quad_t        c_reg;
    sqvs_pkg::quad_t        c_next;
    logic [1:0]             corner_reg;
    logic                   o_valid_reg;
    sqvs_pkg::vertex_t      o_reg;
    sqvs_pkg::vertex_t      o_next;

    // Flow control.
    logic                   out_free;
    logic                   c_done;
    logic                   c_free;
    logic                   b_free;
    logic                   a_free;

    // Stage A to B locals.
    logic [sqvs_pkg::ANGLE_W-1:0]   ang_mod;
    logic [sqvs_pkg::ANGLE_W-1:0]   ang_cos;
    logic signed [17:0]             cen_x;
    logic signed [17:0]             cen_y;
    logic [sqvs_pkg::TEX_W:0]       u_sum;
    logic [sqvs_pkg::TEX_W:0]       v_sum;

    // The output slot can take a vertex when empty or being drained.
    assign out_free = !o_valid_reg || m_tready;
    assign c_done   = c_valid_reg && out_free && (corner_reg == sqvs_pkg::CORNER_LAST);
    assign c_free   = !c_valid_reg || c_done;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free;

    // Reduce the angle, look up sine and cosine, form centers and texture corners.
    always_comb
    begin
        ang_mod = (a_reg.angle >= 9'd360) ? a_reg.angle - 9'd360 : a_reg.angle;
        ang_cos = (ang_mod >= 9'd270) ? ang_mod - 9'd270 : ang_mod + 9'd90;
        cen_x   = signed'({a_reg.pos_x[15], a_reg.pos_x, 1'b0})
                  + signed'({3'b000, a_reg.width});
        cen_y   = signed'({a_reg.pos_y[15], a_reg.pos_y, 1'b0})
                  + signed'({3'b000, a_reg.height});
        u_sum   = {1'b0, a_reg.tex_u} + {1'b0, a_reg.tex_w};
        v_sum   = {1'b0, a_reg.tex_v} + {1'b0, a_reg.tex_h};

        b_next.sin_v  = trig_at(ang_mod);
        b_next.cos_v  = trig_at(ang_cos);
        b_next.width  = a_reg.width;
        b_next.height = a_reg.height;
        b_next.cx2    = sqvs_pkg::CEN_W'(cen_x) <<< sqvs_pkg::TRIG_FRAC_BITS;
        b_next.cy2    = sqvs_pkg::CEN_W'(cen_y) <<< sqvs_pkg::TRIG_FRAC_BITS;
        b_next.depth  = a_reg.depth;
        b_next.u0     = (a_reg.tex_u > sqvs_pkg::TEX_ONE) ? sqvs_pkg::TEX_ONE : a_reg.tex_u;
        b_next.v0     = (a_reg.tex_v > sqvs_pkg::TEX_ONE) ? sqvs_pkg::TEX_ONE : a_reg.tex_v;
        b_next.u1     = (u_sum > {1'b0, sqvs_pkg::TEX_ONE}) ? sqvs_pkg::TEX_ONE
                                                           : u_sum[sqvs_pkg::TEX_W-1:0];
        b_next.v1     = (v_sum > {1'b0, sqvs_pkg::TEX_ONE}) ? sqvs_pkg::TEX_ONE
                                                           : v_sum[sqvs_pkg::TEX_W-1:0];
        b_next.color  = a_reg.color;
        b_next.mirror = a_reg.mirror;
    end

    // Four independent rotation products, shared by all corners of the sprite.
    always_comb
    begin
        c_next.cw     = sqvs_pkg::PROD_W'(b_reg.cos_v)
                        * sqvs_pkg::PROD_W'(signed'({1'b0, b_reg.width}));
        c_next.sh     = sqvs_pkg::PROD_W'(b_reg.sin_v)
                        * sqvs_pkg::PROD_W'(signed'({1'b0, b_reg.height}));
        c_next.sw     = sqvs_pkg::PROD_W'(b_reg.sin_v)
                        * sqvs_pkg::PROD_W'(signed'({1'b0, b_reg.width}));
        c_next.ch     = sqvs_pkg::PROD_W'(b_reg.cos_v)
                        * sqvs_pkg::PROD_W'(signed'({1'b0, b_reg.height}));
        c_next.cx2    = b_reg.cx2;
        c_next.cy2    = b_reg.cy2;
        c_next.depth  = b_reg.depth;
        c_next.u0     = b_reg.u0;
        c_next.v0     = b_reg.v0;
        c_next.u1     = b_reg.u1;
        c_next.v1     = b_reg.v1;
        c_next.color  = b_reg.color;
        c_next.mirror = b_reg.mirror;
    end

    // One corner per cycle from the held sprite while the output is not stalled.
    sqvs_vertex u_vertex (
        .quad   (c_reg),
        .corner (corner_reg),
        .vert   (o_next)
    );

    // Valid bits and the corner counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            corner_reg  <= 2'd0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (c_valid_reg && out_free)
            begin
                corner_reg <= corner_reg + 2'd1;
            end
            if (out_free)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_free && s_tvalid)
        begin
            a_reg.pos_x  <= s_tdata[15:0];
            a_reg.pos_y  <= s_tdata[31:16];
            a_reg.depth  <= s_tdata[47:32];
            a_reg.width  <= s_tdata[62:48];
            a_reg.height <= s_tdata[77:63];
            a_reg.angle  <= s_tdata[86:78];
            a_reg.tex_u  <= s_tdata[103:87];
            a_reg.tex_v  <= s_tdata[120:104];
            a_reg.tex_w  <= s_tdata[137:121];
            a_reg.tex_h  <= s_tdata[154:138];
            a_reg.color  <= s_tdata[178:155];
            a_reg.mirror <= s_tdata[180:179];
        end
        if (b_free && a_valid_reg)
        begin
            b_reg <= b_next;
        end
        if (c_free && b_valid_reg)
        begin
            c_reg <= c_next;
        end
        if (out_free && c_valid_reg)
        begin
            o_reg <= o_next;
        end
    end

    // Output stream.
    assign m_tvalid = o_valid_reg;
    assign m_tlast  = o_reg.last;
    assign m_tdata  = {4'b0000, o_reg.corner, o_reg.color, o_reg.t, o_reg.s,
                       o_reg.z, o_reg.y, o_reg.x};

`ifndef SYNTHESIS
    // A stalled output freezes the corner sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !out_free) |=> $stable(corner_reg))
        else $error("corner counter moved while the output was stalled");

    // A held sprite stays until its last corner has gone to the output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !c_done) |=> c_valid_reg)
        else $error("sprite dropped before all four corners were emitted");

    // Vertices of one quad leave in corner order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (!m_tvalid || (o_reg.corner == $past(o_reg.corner) + 2'd1)))
        else $error("vertex corners out of order");

    // A new sprite is never loaded into the corner stage mid-quad.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_free) |=> (corner_reg == 2'd0))
        else $error("corner counter not at zero for a new sprite");
`endif

endmodule
